// ----- src/peg_in_convex_polygon_check_assert.svh -----
// Assertion macros for the peg-in-polygon check.
// Included by the modules that carry assertions; needs i_clk and i_rst_n in scope.
`ifndef PEG_IN_CONVEX_POLYGON_CHECK_ASSERT_SVH
`define PEG_IN_CONVEX_POLYGON_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define PIC_AST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked at every edge, reset included.
`define PIC_AST_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PIC_AST(lbl, prop, msg)
`define PIC_AST_ALL(lbl, prop, msg)
`endif
`endif

// ----- src/pic_pkg.sv -----
// Shared types and constants of the peg-in-polygon check.
// Used by the controller, the datapath and the top level.
package pic_pkg;

    localparam int RADIUS_W = 16;
    localparam int R2_W     = 32;
    localparam int VERDICT_W = 3;

    typedef enum logic [VERDICT_W-1:0] {
        VD_ILL   = 3'd0,
        VD_FIT   = 3'd1,
        VD_NOFIT = 3'd2,
        VD_FEW   = 3'd3,
        VD_OVF   = 3'd4
    } t_verdict;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_TL_RD,
        ST_TL_SH,
        ST_T_SH,
        ST_T_MUL,
        ST_T_SUB,
        ST_T_CHK,
        ST_GL_RD,
        ST_GL_SH,
        ST_G_SH,
        ST_G_CR,
        ST_G_DOT,
        ST_G_LEN,
        ST_G_D1,
        ST_G_D2,
        ST_G_SUM,
        ST_G_PICK,
        ST_W_CSQ,
        ST_W_CSQ_WAIT,
        ST_W_RL,
        ST_W_RL_WAIT,
        ST_DONE
    } t_state;

    // Read address source for the vertex store.
    typedef enum logic [1:0] {
        RS_ZERO,
        RS_LAST,
        RS_NEXT
    } t_rsel;

    // Operand pairs of the two multipliers.
    typedef enum logic [2:0] {
        PR_TURN,
        PR_CR,
        PR_DOT,
        PR_LEN,
        PR_D1,
        PR_D2
    } t_pair;

    // Destination of the combined products; cross products subtract.
    typedef enum logic [2:0] {
        DST_NONE,
        DST_CR,
        DST_DOT,
        DST_LEN,
        DST_D1,
        DST_D2
    } t_dst;

    typedef struct packed {
        logic     peg_wr;
        logic     vtx_wr;
        logic     clr_count;
        logic     rd_en;
        t_rsel    rd_sel;
        logic     shift;
        logic     mul_en;
        t_pair    pair;
        t_dst     dst;
        logic     sign_clr;
        logic     sign_upd;
        logic     idx_clr;
        logic     idx_inc;
        logic     wm_csq;
        logic     wm_rl;
        logic     csq_ld;
        logic     res_ld;
        t_verdict res_code;
    } t_dp_cmd;

    typedef struct packed {
        logic ovf;
        logic few;
        logic idx_last;
        logic cr_zero;
        logic mixed;
        logic dot_neg;
        logic near;
        logic wm_done;
        logic wide_less;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/pic_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pic_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pic_wmul.sv -----
// Digit-serial unsigned multiplier for the wide distance comparison.
// One 16-bit digit of the second operand per cycle; no package needed.
module pic_wmul #(
    parameter int WA = 35
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [WA-1:0]   i_a,
    input  logic [WA-1:0]   i_b,
    output logic            o_done,
    output logic [2*WA-1:0] o_prod
);

    localparam int DIG = 16;
    localparam int ND  = (WA + DIG - 1) / DIG;
    localparam int WB  = ND * DIG;
    localparam int KW  = $clog2(ND + 1);
    localparam int PW  = 2 * WA;
    localparam int QW  = WA + DIG;

    logic          r_busy;
    logic          r_ppv;
    logic [KW-1:0] r_cnt;
    logic [KW-1:0] r_k;
    logic [WA-1:0] r_a;
    logic [WB-1:0] r_b;
    logic [QW-1:0] r_pp;
    logic [PW-1:0] r_acc;

    assign o_done = r_busy && (r_cnt == '0) && !r_ppv;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_ppv  <= 1'b0;
        end else begin
            r_ppv <= r_busy && (r_cnt != '0);
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Partial product of one digit, then its shifted add in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= WB'(i_b);
            r_cnt <= KW'(ND);
            r_k   <= '0;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_pp  <= QW'(r_a) * QW'(r_b[DIG-1:0]);
                r_b   <= r_b >> DIG;
                r_cnt <= r_cnt - KW'(1);
            end
            if (r_ppv) begin
                r_acc <= r_acc + (PW'(r_pp) << (DIG * r_k));
                r_k   <= r_k + KW'(1);
            end
        end
    end

endmodule

// ----- src/pic_dp.sv -----
// Datapath of the peg-in-polygon check: vertex store, window, multipliers.
// Depends on pic_pkg, pic_ram and pic_wmul.
module pic_dp #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pic_pkg::t_dp_cmd               i_cmd,
    output pic_pkg::t_dp_sts               o_sts,
    input  logic signed [COORD_BITS-1:0]   i_pos_x,
    input  logic signed [COORD_BITS-1:0]   i_pos_y,
    input  logic [pic_pkg::RADIUS_W-1:0]   i_radius,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pic_pkg::VERDICT_W-1:0]  o_verdict
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int P  = 2 * D;
    localparam int S  = P + 1;
    localparam int WW = (S > pic_pkg::R2_W) ? S : pic_pkg::R2_W;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);

    logic [CW-1:0]          r_count;
    logic                   r_ovf;
    logic signed [C-1:0]    r_cen_x, r_cen_y;
    logic [pic_pkg::R2_W-1:0] r_r2;
    logic signed [C-1:0]    r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [AW-1:0]          r_ptr, r_idx;
    logic signed [P-1:0]    r_p0, r_p1;
    logic signed [S-1:0]    r_cr, r_dot, r_len, r_d1, r_d2;
    logic                   r_neg, r_pos;
    logic [2*WW-1:0]        r_csq;
    logic                   r_out_valid;
    logic [pic_pkg::VERDICT_W-1:0] r_verdict;

    logic [AW-1:0]          n_ptr;
    logic                   room;
    logic [C-1:0]           rd_x, rd_y;
    logic signed [D-1:0]    lx, ly, ex, ey, ox, oy, bx, by;
    logic signed [D-1:0]    a0, b0, a1, b1;
    logic signed [P-1:0]    m0, m1;
    logic                   neg_new, pos_new;
    logic [S-1:0]           cr_mag;
    logic signed [S-1:0]    dmin;
    logic                   wm_start, wm_done;
    logic [WW-1:0]          wm_a, wm_b;
    logic [2*WW-1:0]        wm_prod;

    assign room = r_count < CW'(MAX_VERTICES);

    always_comb begin
        unique case (i_cmd.rd_sel)
            pic_pkg::RS_ZERO: n_ptr = '0;
            pic_pkg::RS_LAST: n_ptr = AW'(r_count - CW'(1));
            pic_pkg::RS_NEXT: n_ptr = ((CW'(r_ptr) + CW'(1)) == r_count) ? '0
                                                                          : r_ptr + AW'(1);
            default:          n_ptr = '0;
        endcase
    end

    pic_ram #(.WIDTH(C), .DEPTH(MAX_VERTICES)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (i_cmd.vtx_wr && room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_pos_x),
        .i_re    (i_cmd.rd_en),
        .i_raddr (n_ptr),
        .o_rdata (rd_x)
    );

    pic_ram #(.WIDTH(C), .DEPTH(MAX_VERTICES)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (i_cmd.vtx_wr && room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_pos_y),
        .i_re    (i_cmd.rd_en),
        .i_raddr (n_ptr),
        .o_rdata (rd_y)
    );

    // Window: A is the previous vertex, B the current one, C the next one.
    assign lx = D'(r_ax) - D'(r_bx);
    assign ly = D'(r_ay) - D'(r_by);
    assign ex = D'(r_cx) - D'(r_bx);
    assign ey = D'(r_cy) - D'(r_by);
    assign ox = D'(r_cen_x) - D'(r_bx);
    assign oy = D'(r_cen_y) - D'(r_by);
    assign bx = D'(r_cen_x) - D'(r_cx);
    assign by = D'(r_cen_y) - D'(r_cy);

    always_comb begin
        unique case (i_cmd.pair)
            pic_pkg::PR_TURN: begin a0 = lx; b0 = ey; a1 = ly; b1 = ex; end
            pic_pkg::PR_CR:   begin a0 = ox; b0 = ey; a1 = oy; b1 = ex; end
            pic_pkg::PR_DOT:  begin a0 = ex; b0 = ox; a1 = ey; b1 = oy; end
            pic_pkg::PR_LEN:  begin a0 = ex; b0 = ex; a1 = ey; b1 = ey; end
            pic_pkg::PR_D1:   begin a0 = ox; b0 = ox; a1 = oy; b1 = oy; end
            pic_pkg::PR_D2:   begin a0 = bx; b0 = bx; a1 = by; b1 = by; end
            default:          begin a0 = lx; b0 = ey; a1 = ly; b1 = ex; end
        endcase
    end

    assign m0 = P'(a0) * P'(b0);
    assign m1 = P'(a1) * P'(b1);

    assign neg_new = r_cr[S-1];
    assign pos_new = !r_cr[S-1] && (r_cr != '0);
    assign cr_mag  = r_cr[S-1] ? (S'(~r_cr) + S'(1)) : S'(r_cr);
    assign dmin    = (r_d1 < r_d2) ? r_d1 : r_d2;

    assign wm_start = i_cmd.wm_csq || i_cmd.wm_rl;
    assign wm_a     = i_cmd.wm_csq ? WW'(cr_mag) : WW'($unsigned(r_len));
    assign wm_b     = i_cmd.wm_csq ? WW'(cr_mag) : WW'(r_r2);

    pic_wmul #(.WA(WW)) u_wmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wm_start),
        .i_a     (wm_a),
        .i_b     (wm_b),
        .o_done  (wm_done),
        .o_prod  (wm_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_cen_x     <= '0;
            r_cen_y     <= '0;
            r_r2        <= '0;
            r_neg       <= 1'b0;
            r_pos       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.peg_wr) begin
                r_cen_x <= i_pos_x;
                r_cen_y <= i_pos_y;
                r_r2    <= pic_pkg::R2_W'(i_radius) * pic_pkg::R2_W'(i_radius);
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.clr_count) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.vtx_wr) begin
                if (room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.sign_clr) begin
                r_neg <= 1'b0;
                r_pos <= 1'b0;
            end else if (i_cmd.sign_upd) begin
                r_neg <= r_neg || neg_new;
                r_pos <= r_pos || pos_new;
            end
            if (i_cmd.res_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_ptr <= n_ptr;
        end
        if (i_cmd.shift) begin
            r_ax <= r_bx;
            r_ay <= r_by;
            r_bx <= r_cx;
            r_by <= r_cy;
            r_cx <= signed'(rd_x);
            r_cy <= signed'(rd_y);
        end
        if (i_cmd.mul_en) begin
            r_p0 <= m0;
            r_p1 <= m1;
        end
        case (i_cmd.dst)
            pic_pkg::DST_CR:  r_cr  <= S'(r_p0) - S'(r_p1);
            pic_pkg::DST_DOT: r_dot <= S'(r_p0) + S'(r_p1);
            pic_pkg::DST_LEN: r_len <= S'(r_p0) + S'(r_p1);
            pic_pkg::DST_D1:  r_d1  <= S'(r_p0) + S'(r_p1);
            pic_pkg::DST_D2:  r_d2  <= S'(r_p0) + S'(r_p1);
            default: ;
        endcase
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.csq_ld) begin
            r_csq <= wm_prod;
        end
        if (i_cmd.res_ld) begin
            r_verdict <= i_cmd.res_code;
        end
    end

    assign o_sts.ovf       = r_ovf;
    assign o_sts.few       = r_count < CW'(3);
    assign o_sts.idx_last  = CW'(r_idx) == (r_count - CW'(1));
    assign o_sts.cr_zero   = r_cr == '0;
    assign o_sts.mixed     = (r_neg || neg_new) && (r_pos || pos_new);
    assign o_sts.dot_neg   = r_dot[S-1];
    assign o_sts.near      = WW'($unsigned(dmin)) < WW'(r_r2);
    assign o_sts.wm_done   = wm_done;
    assign o_sts.wide_less = r_csq < wm_prod;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

// ----- src/pic_ctrl.sv -----
// Controller of the peg-in-polygon check: sequences the two vertex walks.
// Depends on pic_pkg and the assertion macro header.
`include "peg_in_convex_polygon_check_assert.svh"
module pic_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_operation,
    input  logic             i_last_vertex,
    input  pic_pkg::t_dp_sts i_sts,
    output pic_pkg::t_dp_cmd o_cmd
);

    pic_pkg::t_state   r_state, n_state;
    logic [1:0]        r_ld, n_ld;
    pic_pkg::t_verdict r_code, n_code;
    logic              accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pic_pkg::ST_IDLE;
            r_ld    <= '0;
            r_code  <= pic_pkg::VD_FIT;
        end else begin
            r_state <= n_state;
            r_ld    <= n_ld;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ld    = r_ld;
        n_code  = r_code;
        unique case (r_state)
            pic_pkg::ST_IDLE: begin
                if (accept && i_operation && i_last_vertex) begin
                    n_state = pic_pkg::ST_JUDGE;
                end
            end
            pic_pkg::ST_JUDGE: begin
                if (i_sts.ovf) begin
                    n_code  = pic_pkg::VD_OVF;
                    n_state = pic_pkg::ST_DONE;
                end else if (i_sts.few) begin
                    n_code  = pic_pkg::VD_FEW;
                    n_state = pic_pkg::ST_DONE;
                end else begin
                    n_ld    = '0;
                    n_state = pic_pkg::ST_TL_RD;
                end
            end
            pic_pkg::ST_TL_RD: n_state = pic_pkg::ST_TL_SH;
            pic_pkg::ST_TL_SH: begin
                if (r_ld == 2'd2) begin
                    n_state = pic_pkg::ST_T_MUL;
                end else begin
                    n_ld    = r_ld + 2'd1;
                    n_state = pic_pkg::ST_TL_RD;
                end
            end
            pic_pkg::ST_T_SH:  n_state = pic_pkg::ST_T_MUL;
            pic_pkg::ST_T_MUL: n_state = pic_pkg::ST_T_SUB;
            pic_pkg::ST_T_SUB: n_state = pic_pkg::ST_T_CHK;
            pic_pkg::ST_T_CHK: begin
                if (i_sts.mixed) begin
                    n_code  = pic_pkg::VD_ILL;
                    n_state = pic_pkg::ST_DONE;
                end else if (i_sts.idx_last) begin
                    n_ld    = '0;
                    n_state = pic_pkg::ST_GL_RD;
                end else begin
                    n_state = pic_pkg::ST_T_SH;
                end
            end
            pic_pkg::ST_GL_RD: n_state = pic_pkg::ST_GL_SH;
            pic_pkg::ST_GL_SH: begin
                if (r_ld == 2'd1) begin
                    n_state = pic_pkg::ST_G_CR;
                end else begin
                    n_ld    = r_ld + 2'd1;
                    n_state = pic_pkg::ST_GL_RD;
                end
            end
            pic_pkg::ST_G_SH:  n_state = pic_pkg::ST_G_CR;
            pic_pkg::ST_G_CR:  n_state = pic_pkg::ST_G_DOT;
            pic_pkg::ST_G_DOT: n_state = pic_pkg::ST_G_LEN;
            pic_pkg::ST_G_LEN: begin
                // A center on the edge line or on both sides fails at once.
                if (i_sts.cr_zero || i_sts.mixed) begin
                    n_code  = pic_pkg::VD_NOFIT;
                    n_state = pic_pkg::ST_DONE;
                end else begin
                    n_state = pic_pkg::ST_G_D1;
                end
            end
            pic_pkg::ST_G_D1:  n_state = pic_pkg::ST_G_D2;
            pic_pkg::ST_G_D2:  n_state = pic_pkg::ST_G_SUM;
            pic_pkg::ST_G_SUM: n_state = pic_pkg::ST_G_PICK;
            pic_pkg::ST_G_PICK: begin
                if (!i_sts.dot_neg) begin
                    n_state = pic_pkg::ST_W_CSQ;
                end else if (i_sts.near) begin
                    n_code  = pic_pkg::VD_NOFIT;
                    n_state = pic_pkg::ST_DONE;
                end else if (i_sts.idx_last) begin
                    n_code  = pic_pkg::VD_FIT;
                    n_state = pic_pkg::ST_DONE;
                end else begin
                    n_state = pic_pkg::ST_G_SH;
                end
            end
            pic_pkg::ST_W_CSQ: n_state = pic_pkg::ST_W_CSQ_WAIT;
            pic_pkg::ST_W_CSQ_WAIT: begin
                if (i_sts.wm_done) begin
                    n_state = pic_pkg::ST_W_RL;
                end
            end
            pic_pkg::ST_W_RL: n_state = pic_pkg::ST_W_RL_WAIT;
            pic_pkg::ST_W_RL_WAIT: begin
                if (i_sts.wm_done) begin
                    if (i_sts.wide_less) begin
                        n_code  = pic_pkg::VD_NOFIT;
                        n_state = pic_pkg::ST_DONE;
                    end else if (i_sts.idx_last) begin
                        n_code  = pic_pkg::VD_FIT;
                        n_state = pic_pkg::ST_DONE;
                    end else begin
                        n_state = pic_pkg::ST_G_SH;
                    end
                end
            end
            pic_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = pic_pkg::ST_IDLE;
                end
            end
            default: n_state = pic_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.peg_wr     = 1'b0;
        o_cmd.vtx_wr     = 1'b0;
        o_cmd.clr_count  = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = pic_pkg::RS_NEXT;
        o_cmd.shift      = 1'b0;
        o_cmd.mul_en     = 1'b0;
        o_cmd.pair       = pic_pkg::PR_TURN;
        o_cmd.dst        = pic_pkg::DST_NONE;
        o_cmd.sign_clr   = 1'b0;
        o_cmd.sign_upd   = 1'b0;
        o_cmd.idx_clr    = 1'b0;
        o_cmd.idx_inc    = 1'b0;
        o_cmd.wm_csq     = 1'b0;
        o_cmd.wm_rl      = 1'b0;
        o_cmd.csq_ld     = 1'b0;
        o_cmd.res_ld     = 1'b0;
        o_cmd.res_code   = r_code;
        unique case (r_state)
            pic_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    o_cmd.peg_wr = !i_operation;
                    o_cmd.vtx_wr = i_operation;
                end
            end
            pic_pkg::ST_JUDGE: begin
                o_cmd.sign_clr = 1'b1;
                o_cmd.idx_clr  = 1'b1;
            end
            pic_pkg::ST_TL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = (r_ld == 2'd0) ? pic_pkg::RS_LAST : pic_pkg::RS_NEXT;
            end
            pic_pkg::ST_TL_SH, pic_pkg::ST_T_SH, pic_pkg::ST_GL_SH, pic_pkg::ST_G_SH: begin
                o_cmd.shift = 1'b1;
            end
            pic_pkg::ST_T_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.pair   = pic_pkg::PR_TURN;
                o_cmd.rd_en  = 1'b1;
            end
            pic_pkg::ST_T_SUB: o_cmd.dst = pic_pkg::DST_CR;
            pic_pkg::ST_T_CHK: begin
                o_cmd.sign_upd = 1'b1;
                if (!i_sts.mixed) begin
                    if (i_sts.idx_last) begin
                        o_cmd.sign_clr = 1'b1;
                        o_cmd.idx_clr  = 1'b1;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            pic_pkg::ST_GL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = (r_ld == 2'd0) ? pic_pkg::RS_ZERO : pic_pkg::RS_NEXT;
            end
            pic_pkg::ST_G_CR: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.pair   = pic_pkg::PR_CR;
                o_cmd.rd_en  = 1'b1;
            end
            pic_pkg::ST_G_DOT: begin
                o_cmd.dst    = pic_pkg::DST_CR;
                o_cmd.mul_en = 1'b1;
                o_cmd.pair   = pic_pkg::PR_DOT;
            end
            pic_pkg::ST_G_LEN: begin
                o_cmd.dst      = pic_pkg::DST_DOT;
                o_cmd.mul_en   = 1'b1;
                o_cmd.pair     = pic_pkg::PR_LEN;
                o_cmd.sign_upd = 1'b1;
            end
            pic_pkg::ST_G_D1: begin
                o_cmd.dst    = pic_pkg::DST_LEN;
                o_cmd.mul_en = 1'b1;
                o_cmd.pair   = pic_pkg::PR_D1;
            end
            pic_pkg::ST_G_D2: begin
                o_cmd.dst    = pic_pkg::DST_D1;
                o_cmd.mul_en = 1'b1;
                o_cmd.pair   = pic_pkg::PR_D2;
            end
            pic_pkg::ST_G_SUM: o_cmd.dst = pic_pkg::DST_D2;
            pic_pkg::ST_G_PICK: begin
                o_cmd.idx_inc = i_sts.dot_neg && !i_sts.near && !i_sts.idx_last;
            end
            pic_pkg::ST_W_CSQ: o_cmd.wm_csq = 1'b1;
            pic_pkg::ST_W_CSQ_WAIT: o_cmd.csq_ld = i_sts.wm_done;
            pic_pkg::ST_W_RL: o_cmd.wm_rl = 1'b1;
            pic_pkg::ST_W_RL_WAIT: begin
                o_cmd.idx_inc = i_sts.wm_done && !i_sts.wide_less && !i_sts.idx_last;
            end
            pic_pkg::ST_DONE: begin
                o_cmd.res_ld    = i_sts.out_free;
                o_cmd.clr_count = i_sts.out_free;
            end
            default: ;
        endcase
    end

    `PIC_AST(a_res_slot_free, o_cmd.res_ld |-> i_sts.out_free, "verdict loaded over a pending one")
    `PIC_AST(a_walk_needs_three, (r_state == pic_pkg::ST_TL_RD) |-> (!i_sts.few && !i_sts.ovf), "walk started on a short or overflowed polygon")
    `PIC_AST(a_wmul_done_in_wait, i_sts.wm_done |-> (r_state == pic_pkg::ST_W_CSQ_WAIT || r_state == pic_pkg::ST_W_RL_WAIT), "wide product finished outside a wait state")
    `PIC_AST_ALL(a_ready_only_idle, o_in_ready |-> (r_state == pic_pkg::ST_IDLE), "input taken while busy")

endmodule

// ----- src/peg_in_convex_polygon_check.sv -----
// Channel   Direction  Transfer when                  Payload
// input     in         i_in_valid & o_in_ready        operation, pos_x, pos_y, radius, last_vertex
// result    out        o_out_valid & i_out_ready      verdict
//
// A peg item or a non-final vertex leaves the block idle, ready for the next item. The final
// vertex starts a verdict: a turn walk over the vertices, then an edge walk that runs the
// wide multiplier twice on each edge whose projection does not fall before its start
// (operand width W = max(2*COORD_BITS+3, 32), 35 bits at defaults).
// Input is taken only while no verdict is in work; a finished verdict waits under output stall.
// Reset is synchronous and clears counts, flags, the center and the radius.
// Top level of the peg-in-polygon check; depends on pic_pkg, pic_ctrl and pic_dp.
module peg_in_convex_polygon_check #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic [pic_pkg::RADIUS_W-1:0]  i_radius,
    input  logic                          i_last_vertex,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pic_pkg::VERDICT_W-1:0] o_verdict
);

    pic_pkg::t_dp_cmd cmd;
    pic_pkg::t_dp_sts sts;

    pic_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_last_vertex (i_last_vertex),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    pic_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_radius    (i_radius),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_verdict   (o_verdict)
    );

endmodule

// ----- dv/pic_checker.sv -----
// Scoreboard for the peg-in-polygon check: watches both channels, predicts each verdict
// and compares it with the one the block returns. Depends on pic_pkg.
`timescale 1ns / 1ps
module pic_checker #(
    parameter int MAX_VERTICES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_radius,
    input  logic        i_last_vertex,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_verdict,
    output int          o_pending,
    output int          o_fail_count
);

    longint            poly_x [MAX_VERTICES];
    longint            poly_y [MAX_VERTICES];
    int                poly_count;
    logic              poly_ovf;
    longint            peg_x;
    longint            peg_y;
    longint            peg_r;
    pic_pkg::t_verdict verdict_q[$];
    int                fails;

    assign o_pending    = verdict_q.size();
    assign o_fail_count = fails;

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic pic_pkg::t_verdict judge_polygon();
        int           l;
        int           r;
        logic         neg;
        logic         pos;
        longint       ex, ey, ox, oy, bx, by, cr, turn, d1, d2;
        longint       r2;
        logic [127:0] cr_sq;
        logic [127:0] lim_sq;
        r2 = peg_r * peg_r;
        if (poly_ovf) return pic_pkg::VD_OVF;
        if (poly_count < 3) return pic_pkg::VD_FEW;
        neg = 0;
        pos = 0;
        for (int i = 0; i < poly_count; i++) begin
            l = (i == 0) ? poly_count - 1 : i - 1;
            r = (i + 1 == poly_count) ? 0 : i + 1;
            turn = (poly_x[l] - poly_x[i]) * (poly_y[r] - poly_y[i])
                 - (poly_y[l] - poly_y[i]) * (poly_x[r] - poly_x[i]);
            if (turn < 0) neg = 1;
            if (turn > 0) pos = 1;
            if (neg && pos) return pic_pkg::VD_ILL;
        end
        neg = 0;
        pos = 0;
        for (int i = 0; i < poly_count; i++) begin
            r  = (i + 1 == poly_count) ? 0 : i + 1;
            ex = poly_x[r] - poly_x[i];
            ey = poly_y[r] - poly_y[i];
            ox = peg_x - poly_x[i];
            oy = peg_y - poly_y[i];
            cr = ox * ey - oy * ex;
            if (cr == 0) return pic_pkg::VD_NOFIT;
            if (cr < 0) neg = 1; else pos = 1;
            if (neg && pos) return pic_pkg::VD_NOFIT;
            if (ex * ox + ey * oy < 0) begin
                bx = peg_x - poly_x[r];
                by = peg_y - poly_y[r];
                d1 = ox * ox + oy * oy;
                d2 = bx * bx + by * by;
                if (((d1 < d2) ? d1 : d2) < r2) return pic_pkg::VD_NOFIT;
            end else begin
                cr_sq  = 128'(abs64(cr)) * 128'(abs64(cr));
                lim_sq = 128'(r2) * 128'(ex * ex + ey * ey);
                if (cr_sq < lim_sq) return pic_pkg::VD_NOFIT;
            end
        end
        return pic_pkg::VD_FIT;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poly_count = 0;
            poly_ovf   = 0;
            peg_x      = 0;
            peg_y      = 0;
            peg_r      = 0;
            fails      <= 0;
            verdict_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (!i_operation) begin
                    peg_x      = longint'($signed(i_pos_x));
                    peg_y      = longint'($signed(i_pos_y));
                    peg_r      = longint'(i_radius);
                    poly_count = 0;
                    poly_ovf   = 0;
                end else begin
                    if (poly_count < MAX_VERTICES) begin
                        poly_x[poly_count] = longint'($signed(i_pos_x));
                        poly_y[poly_count] = longint'($signed(i_pos_y));
                        poly_count++;
                    end else begin
                        poly_ovf = 1;
                    end
                    if (i_last_vertex) begin
                        verdict_q.push_back(judge_polygon());
                        poly_count = 0;
                        poly_ovf   = 0;
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict transfer, actual %0d", $time, i_verdict);
                    fails <= fails + 1;
                end else if (i_verdict !== verdict_q[0]) begin
                    $display("%0t: verdict mismatch, expected %0d actual %0d",
                             $time, verdict_q[0], i_verdict);
                    fails <= fails + 1;
                    void'(verdict_q.pop_front());
                end else begin
                    void'(verdict_q.pop_front());
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Stimulus and verdict for the peg-in-polygon check: directed shapes, then random
// convex polygons with pegs. Depends on pic_pkg, pic_checker and the block.
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [15:0] i_pos_x;
    logic [15:0] i_pos_y;
    logic [15:0] i_radius;
    logic        i_last_vertex;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_verdict;
    int          pending;
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          idle_cycles;
    int          item_count;

    peg_in_convex_polygon_check u_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_operation,
        .i_pos_x, .i_pos_y, .i_radius, .i_last_vertex,
        .o_out_valid, .i_out_ready, .o_verdict
    );

    pic_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_operation,
        .i_pos_x, .i_pos_y, .i_radius, .i_last_vertex,
        .i_out_valid(o_out_valid), .i_out_ready, .i_verdict(o_verdict),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial i_clk = 0;
    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: cycles in a row with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(logic op, int x, int y, int r, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_operation   = op;
        i_pos_x       = clamp16(x);
        i_pos_y       = clamp16(y);
        i_radius      = r[15:0];
        i_last_vertex = last;
        i_in_valid    = 1;
        #1;
        while (!o_in_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
        item_count++;
    endtask

    task automatic send_peg(int x, int y, int r);
        send_item(1'b0, x, y, r, 1'($urandom_range(1)));
    endtask

    task automatic send_vertex(int x, int y, logic last);
        send_item(1'b1, x, y, $urandom_range(65535), last);
    endtask

    // Polygon of n corners around (cx, cy), either winding; not convex if the angles pass a full turn.
    task automatic send_convex(int cx, int cy, int rad, int n);
        real ang;
        real step;
        real dir;
        ang  = $urandom_range(628) / 100.0;
        dir  = $urandom_range(1) ? 1.0 : -1.0;
        step = 6.28318 / n;
        for (int k = 0; k < n; k++) begin
            send_vertex(cx + int'(rad * $cos(ang)), cy + int'(rad * $sin(ang)), k == n - 1);
            ang += dir * step * (0.6 + $urandom_range(60) / 100.0) * (k < n - 1);
        end
    endtask

    initial begin
        int cx;
        int cy;
        int rad;
        int n;
        i_rst_n        = 0;
        i_in_valid     = 0;
        i_operation    = 0;
        i_pos_x        = 0;
        i_pos_y        = 0;
        i_radius       = 0;
        i_last_vertex  = 0;
        send_idle_pct  = 11;
        recv_stall_pct = 74;
        item_count     = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // A vertex run with no peg uses the reset center and radius.
        send_vertex(-5, -5, 0);
        send_vertex(5, -5, 0);
        send_vertex(0, 5, 1);
        // A square that holds the peg, then a peg too large for it.
        send_peg(0, 0, 100);
        send_vertex(-1000, -1000, 0);
        send_vertex(1000, -1000, 0);
        send_vertex(1000, 1000, 0);
        send_vertex(-1000, 1000, 1);
        send_peg(0, 0, 65535);
        send_convex(0, 0, 1000, 4);
        // Bow tie: turns of both signs.
        send_peg(0, 0, 1);
        send_vertex(-10, -10, 0);
        send_vertex(10, 10, 0);
        send_vertex(10, -10, 0);
        send_vertex(-10, 10, 1);
        // Too few vertices.
        send_vertex(1, 2, 0);
        send_vertex(3, 4, 1);
        // Center on an edge line, with a collinear middle vertex.
        send_peg(0, -50, 0);
        send_vertex(-50, -50, 0);
        send_vertex(0, -50, 0);
        send_vertex(50, -50, 0);
        send_vertex(0, 50, 1);
        // Extreme coordinates.
        send_peg(-32768, 32767, 0);
        send_vertex(-32768, -32768, 0);
        send_vertex(32767, -32768, 0);
        send_vertex(32767, 32767, 0);
        send_vertex(-32768, 32767, 1);
        send_peg(0, 0, 3);
        send_vertex(-32768, -32768, 0);
        send_vertex(32767, -32768, 0);
        send_vertex(0, 32767, 1);

        while (item_count < 290) begin
            if (item_count > 200) begin
                send_idle_pct  = 74;
                recv_stall_pct = 11;
            end
            rad = $urandom_range(3) == 0 ? $urandom_range(32767) : $urandom_range(2, 3000);
            cx  = $urandom_range(65535) - 32768;
            cy  = $urandom_range(65535) - 32768;
            case ($urandom_range(9))
                0: send_item(1'($urandom_range(1)), $urandom_range(65535) - 32768,
                             $urandom_range(65535) - 32768, $urandom_range(65535),
                             1'($urandom_range(1)));
                1: begin
                    n = $urandom_range(1, 2);
                    for (int k = 0; k < n; k++)
                        send_vertex(cx + $urandom_range(50), cy - $urandom_range(50), k == n - 1);
                end
                default: begin
                    if ($urandom_range(4) != 0)
                        send_peg(cx + $urandom_range(rad / 2) - rad / 4,
                                 cy + $urandom_range(rad / 2) - rad / 4,
                                 $urandom_range(7) == 0 ? $urandom_range(65535)
                                                        : $urandom_range(rad));
                    n = $urandom_range(15) == 0 ? $urandom_range(9, 40) : $urandom_range(3, 8);
                    send_convex(cx, cy, rad, n);
                end
            endcase
        end

        // Store filled exactly, then one vertex too many, with neither side idling.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_peg(0, 0, 10);
        send_convex(0, 0, 30000, 257);
        i_in_valid = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/pic_pkg.sv
src/pic_ram.sv
src/pic_wmul.sv
src/pic_dp.sv
src/pic_ctrl.sv
src/peg_in_convex_polygon_check.sv
dv/pic_checker.sv
dv/tb_top.sv
